// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SBS_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SBS_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define SBS_ASSERT_NXT_ALWAYS(label, clk, pre, post, msg) \
   label: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/sbs_pkg.sv =====
// Types, character codes and helper functions for the script block splitter.
package sbs_pkg;

   localparam int SBS_OFFSET_BITS = 24;
   localparam int SBS_DEPTH_BITS  = 8;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = 2;
   localparam int FIFO_CNT_BITS = 3;

   localparam logic [2:0] KW_LEN = 3'd6;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef enum logic [1:0] {
      PH_SEARCH,
      PH_AWAIT,
      PH_BLOCK
   } phase_type;

   typedef enum logic [2:0] {
      LM_CODE,
      LM_DQ,
      LM_SQ,
      LM_LINE,
      LM_BLOCKC
   } lex_mode_type;

   typedef enum logic [1:0] {
      LA_NONE,
      LA_SLASH,
      LA_STAR
   } look_type;

   // Write requests from the scanner into the result queue.
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   // Character of the keyword "script" at a given match count.
   function automatic logic [7:0] kw_char(input logic [2:0] k);
      logic [7:0] ch;
      case (k)
         3'd0: ch = 8'h73;
         3'd1: ch = 8'h63;
         3'd2: ch = 8'h72;
         3'd3: ch = 8'h69;
         3'd4: ch = 8'h70;
         3'd5: ch = 8'h74;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/sbs_scan.sv =====
// Per-byte scanner: keyword search, brace tracking and fragment generation.
module sbs_scan import sbs_pkg::*; #(
   parameter int OFFSET_BITS = SBS_OFFSET_BITS,
   parameter int DEPTH_BITS  = SBS_DEPTH_BITS,
   localparam int RW = 2 * OFFSET_BITS + 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    text_byte,
   input  logic          final_byte,
   output push_type      push,
   output logic [RW-1:0] word_first,
   output logic [RW-1:0] word_second
);

   localparam int OB = OFFSET_BITS;

   logic [OB:0]            position_ff, position_in;
   logic [OB:0]            text_start_ff, text_start_in;
   logic [OB-1:0]          block_start_ff, block_start_in;
   phase_type              phase_ff, phase_in;
   logic [2:0]             kw_ff, kw_in;
   logic                   prev_alnum_ff;
   logic [7:0]             prev_byte_ff;
   logic [DEPTH_BITS-1:0]  depth_ff, depth_in;
   lex_mode_type           mode_ff, mode_in;
   look_type               look_ff, look_in;
   logic                   ovf_ff, ovf_in;

   logic                   sat;
   logic [OB-1:0]          idx;
   logic [2:0]             kw_base;
   logic                   do_search;
   logic                   enter;
   logic                   close;
   logic                   handled;
   logic                   kw_hit;
   logic                   blk_emit;
   logic [OB:0]            bs_ext;
   logic [OB:0]            from_second;

   // Next state for one byte.
   always_comb begin
      sat            = position_ff[OB];
      idx            = sat ? {OB{1'b1}} : position_ff[OB-1:0];
      position_in    = sat ? position_ff : position_ff + (OB+1)'(1);
      ovf_in         = ovf_ff | sat;
      text_start_in  = text_start_ff;
      block_start_in = block_start_ff;
      phase_in       = phase_ff;
      kw_in          = kw_ff;
      depth_in       = depth_ff;
      mode_in        = mode_ff;
      look_in        = look_ff;
      kw_base        = kw_ff;
      do_search      = 1'b0;
      enter          = 1'b0;
      close          = 1'b0;
      handled        = 1'b0;
      kw_hit         = 1'b0;

      case (phase_ff)
         PH_SEARCH: begin
            if (kw_ff == KW_LEN) begin
               if (is_alnum(text_byte)) begin
                  kw_in = 3'd0;
               end else if (is_space(text_byte)) begin
                  phase_in = PH_AWAIT;
                  kw_in    = 3'd0;
               end else if (text_byte == CH_LBRACE) begin
                  enter = 1'b1;
               end else begin
                  kw_base   = 3'd0;
                  do_search = 1'b1;
               end
            end else begin
               do_search = 1'b1;
            end
         end
         PH_AWAIT: begin
            if (text_byte == CH_LBRACE) begin
               enter = 1'b1;
            end else if (!is_space(text_byte)) begin
               phase_in  = PH_SEARCH;
               kw_base   = 3'd0;
               do_search = 1'b1;
            end
         end
         PH_BLOCK: begin
            // Resolve a pending slash or star against this byte first.
            if (look_ff == LA_SLASH) begin
               look_in = LA_NONE;
               if (text_byte == CH_SLASH) begin
                  mode_in = LM_LINE;
                  handled = 1'b1;
               end else if (text_byte == CH_STAR) begin
                  mode_in = LM_BLOCKC;
                  handled = 1'b1;
               end
            end else if (look_ff == LA_STAR) begin
               look_in = LA_NONE;
               if (text_byte == CH_SLASH) begin
                  mode_in = LM_CODE;
                  handled = 1'b1;
               end
            end
            if (!handled) begin
               case (mode_ff)
                  LM_CODE: begin
                     if (text_byte == CH_DQUOTE) begin
                        mode_in = LM_DQ;
                     end else if (text_byte == CH_SQUOTE) begin
                        mode_in = LM_SQ;
                     end else if (text_byte == CH_SLASH) begin
                        look_in = LA_SLASH;
                     end else if (text_byte == CH_LBRACE) begin
                        if (&depth_ff) begin
                           ovf_in = 1'b1;
                        end else begin
                           depth_in = depth_ff + DEPTH_BITS'(1);
                        end
                     end else if (text_byte == CH_RBRACE) begin
                        if (depth_ff[DEPTH_BITS-1:1] == '0) begin
                           depth_in = '0;
                           close    = 1'b1;
                        end else begin
                           depth_in = depth_ff - DEPTH_BITS'(1);
                        end
                     end
                  end
                  LM_DQ: begin
                     if (text_byte == CH_DQUOTE && prev_byte_ff != CH_BSLASH) begin
                        mode_in = LM_CODE;
                     end
                  end
                  LM_SQ: begin
                     if (text_byte == CH_SQUOTE && prev_byte_ff != CH_BSLASH) begin
                        mode_in = LM_CODE;
                     end
                  end
                  LM_LINE: begin
                     if (text_byte == CH_LF) begin
                        mode_in = LM_CODE;
                     end
                  end
                  default: begin
                     if (text_byte == CH_STAR) begin
                        look_in = LA_STAR;
                     end
                  end
               endcase
            end
         end
         default: begin
            phase_in = PH_SEARCH;
         end
      endcase

      if (do_search) begin
         kw_hit = (kw_base < KW_LEN) && (text_byte == kw_char(kw_base)) &&
                  (kw_base != 3'd0 || !prev_alnum_ff);
         if (kw_hit) begin
            if (kw_base == 3'd0) begin
               block_start_in = idx;
            end
            kw_in = kw_base + 3'd1;
         end else begin
            kw_in = 3'd0;
         end
      end

      if (enter) begin
         phase_in = PH_BLOCK;
         depth_in = DEPTH_BITS'(1);
         mode_in  = LM_CODE;
         look_in  = LA_NONE;
         kw_in    = 3'd0;
      end

      if (close) begin
         text_start_in = position_in;
         phase_in      = PH_SEARCH;
         kw_in         = 3'd0;
         mode_in       = LM_CODE;
         look_in       = LA_NONE;
      end
   end

   // Fragments caused by this byte: optional plain text, then the closing one.
   always_comb begin
      blk_emit    = close | (final_byte & (phase_in == PH_BLOCK));
      bs_ext      = {1'b0, block_start_in};
      push.first  = accept & blk_emit & (bs_ext > text_start_ff);
      push.second = accept & (blk_emit | (final_byte & (position_in > text_start_ff)));
      from_second = blk_emit ? bs_ext : text_start_ff;
      word_first  = {1'b0, text_start_ff[OB-1:0], bs_ext - text_start_ff, 1'b0, ovf_in};
      word_second = {blk_emit, from_second[OB-1:0], position_in - from_second, 1'b1, ovf_in};
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && final_byte)) begin
         position_ff    <= '0;
         text_start_ff  <= '0;
         block_start_ff <= '0;
         phase_ff       <= PH_SEARCH;
         kw_ff          <= 3'd0;
         prev_alnum_ff  <= 1'b0;
         prev_byte_ff   <= 8'h00;
         depth_ff       <= '0;
         mode_ff        <= LM_CODE;
         look_ff        <= LA_NONE;
         ovf_ff         <= 1'b0;
      end else if (accept) begin
         position_ff    <= position_in;
         text_start_ff  <= text_start_in;
         block_start_ff <= block_start_in;
         phase_ff       <= phase_in;
         kw_ff          <= kw_in;
         prev_alnum_ff  <= is_alnum(text_byte);
         prev_byte_ff   <= text_byte;
         depth_ff       <= depth_in;
         mode_ff        <= mode_in;
         look_ff        <= look_in;
         ovf_ff         <= ovf_in;
      end
   end

endmodule

// ===== rtl/sbs_fifo.sv =====
// Result queue: takes up to two fragments per cycle, hands out one per transfer.
module sbs_fifo import sbs_pkg::*; #(
   parameter int RW = 2 * SBS_OFFSET_BITS + 4
) (
   input  logic          clock,
   input  logic          reset,
   input  push_type      push,
   input  logic [RW-1:0] word_first,
   input  logic [RW-1:0] word_second,
   output logic          room,
   output logic          rd_valid,
   input  logic          rd_ready,
   output logic [RW-1:0] rd_word
);

   logic [RW-1:0]              ent_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0]   count_ff, count_in;
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_nx;
   logic [FIFO_CNT_BITS-1:0]   n_push;
   logic                       pop;

   always_comb begin
      pop       = rd_valid & rd_ready;
      n_push    = FIFO_CNT_BITS'(push.first) + FIFO_CNT_BITS'(push.second);
      wr_ptr_nx = wr_ptr_ff + FIFO_PTR_BITS'(1);
      wr_ptr_in = wr_ptr_ff + n_push[FIFO_PTR_BITS-1:0];
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + n_push - FIFO_CNT_BITS'(pop);
   end

   // Accept a byte only with space for the two fragments it may cause.
   assign room     = count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - 2);
   assign rd_valid = count_ff != '0;
   assign rd_word  = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push.first) begin
         ent_ff[wr_ptr_ff] <= word_first;
         if (push.second) begin
            ent_ff[wr_ptr_nx] <= word_second;
         end
      end else if (push.second) begin
         ent_ff[wr_ptr_ff] <= word_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/script_block_splitter.sv =====
// Script block splitter: source bytes in, fragment records out.
// Fragments are registered in the four-entry result queue, read out in order.
// One byte per cycle while the queue has room; a byte closing a block after
// plain text gives two fragments, drained one per cycle when rsp_ready is high.
// Reset: synchronous, clears all scan state and empties the result queue.
module script_block_splitter import sbs_pkg::*; #(
   parameter int OFFSET_BITS = SBS_OFFSET_BITS,
   parameter int DEPTH_BITS  = SBS_DEPTH_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_text_byte,
   input  logic                 req_final_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_fragment_kind,
   output logic [OFFSET_BITS-1:0] rsp_fragment_start,
   output logic [OFFSET_BITS:0] rsp_fragment_length,
   output logic                 rsp_last_of_step,
   output logic                 rsp_limit_hit
);

   localparam int RW = 2 * OFFSET_BITS + 4;

   push_type      push;
   logic [RW-1:0] word_first;
   logic [RW-1:0] word_second;
   logic [RW-1:0] rd_word;
   logic          accept;

   assign accept = req_valid & req_ready;

   sbs_scan #(
      .OFFSET_BITS (OFFSET_BITS),
      .DEPTH_BITS  (DEPTH_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .final_byte  (req_final_byte),
      .push        (push),
      .word_first  (word_first),
      .word_second (word_second)
   );

   sbs_fifo #(
      .RW (RW)
   ) u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .word_first  (word_first),
      .word_second (word_second),
      .room        (req_ready),
      .rd_valid    (rsp_valid),
      .rd_ready    (rsp_ready),
      .rd_word     (rd_word)
   );

   assign {rsp_fragment_kind, rsp_fragment_start, rsp_fragment_length,
           rsp_last_of_step, rsp_limit_hit} = rd_word;

endmodule

// ===== rtl/sbs_checker.sv =====
// Port-level checks for the script block splitter, bound to the top level.
`include "assert_macros.svh"

module sbs_checker #(
   parameter int OFFSET_BITS = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [7:0]             req_text_byte,
   input logic                   req_final_byte,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_fragment_kind,
   input logic [OFFSET_BITS-1:0] rsp_fragment_start,
   input logic [OFFSET_BITS:0]   rsp_fragment_length,
   input logic                   rsp_last_of_step,
   input logic                   rsp_limit_hit
);

   // Hold a stalled fragment.
   `SBS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_fragment_kind, rsp_fragment_start, rsp_fragment_length, rsp_last_of_step, rsp_limit_hit}), "stalled fragment changed")

   `SBS_ASSERT_IMP(a_len_nonzero, clock, reset, rsp_valid, rsp_fragment_length != '0, "fragment of zero length")

   `SBS_ASSERT_IMP(a_ready_empty, clock, reset, !rsp_valid, req_ready, "input stalled with queue empty")

   `SBS_ASSERT_NXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "fragment pending after reset")

endmodule

bind script_block_splitter sbs_checker #(.OFFSET_BITS(OFFSET_BITS)) u_sbs_checker (.*);
